### hdl/orl_pkg.sv
// Shared types and constants for the object record loader.
package orl_pkg;

  localparam int MEM_BYTES      = 4096;
  localparam int MAX_DATA_BYTES = 6;
  localparam int ADDR_W         = 12;
  localparam int LINE_W         = 16;
  localparam int COUNT_W        = $clog2(MAX_DATA_BYTES + 1);

  // Upper address bound, one bit wider than an address.
  localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_BYTES);

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FORMAT = 2'd1,
    STATUS_MEMORY = 2'd2,
    STATUS_DONE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_file;
  } char_word_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    status_t           status;
    logic [LINE_W-1:0] error_line;
    logic              last;
  } result_word_t;

  // One accepted character's work for the back end: some writes, then a status.
  typedef struct packed {
    logic [COUNT_W-1:0]                  n_writes;
    logic [ADDR_W-1:0]                   base;
    logic [MAX_DATA_BYTES-1:0][7:0]      bytes;
    status_t                             status;
    logic [LINE_W-1:0]                   line_count;
  } job_t;

endpackage

### hdl/orl_front.sv
// Front end: column checks per character and line close decisions.
module orl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  orl_pkg::char_word_t char_word,
  input  logic                q_full,
  output logic                push,
  output orl_pkg::job_t       job
);

  typedef enum logic [1:0] {
    KIND_UNDECIDED = 2'd0,
    KIND_COMMENT   = 2'd1,
    KIND_RECORD    = 2'd2
  } kind_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [3:0] MAX_HEX    = 4'(2 * orl_pkg::MAX_DATA_BYTES);

  logic [4:0]                    column, column_next;
  kind_t                         line_kind, line_kind_next;
  logic [orl_pkg::ADDR_W-1:0]    line_address, line_address_next;
  logic [orl_pkg::ADDR_W:0]      prev_end, prev_end_next;
  logic                          none_yet, none_yet_next;
  logic [orl_pkg::MAX_DATA_BYTES-1:0][7:0] data_bytes, data_bytes_next;
  logic [3:0]                    hex_count, hex_count_next;
  logic                          data_ended, data_ended_next;
  logic                          line_ok, line_ok_next;
  logic [orl_pkg::LINE_W-1:0]    line_count, line_count_next;
  orl_pkg::status_t              halted, halted_next;

  logic                          hex_ok;
  logic [3:0]                    hex_val;
  logic [2:0]                    byte_idx;
  logic [orl_pkg::COUNT_W-1:0]   count;
  logic [orl_pkg::ADDR_W:0]      end_sum;
  logic [orl_pkg::ADDR_W:0]      room;
  logic [orl_pkg::COUNT_W-1:0]   n_writes;
  logic                          do_close;

  assign char_stall = q_full;
  assign push       = char_valid && !q_full;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (char_word.ch >= 8'h30 && char_word.ch <= 8'h39) begin
      hex_val = char_word.ch[3:0];
    end else if ((char_word.ch >= 8'h61 && char_word.ch <= 8'h66) ||
                 (char_word.ch >= 8'h41 && char_word.ch <= 8'h46)) begin
      hex_val = char_word.ch[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign byte_idx = hex_count[3:1];
  assign count    = orl_pkg::COUNT_W'(hex_count[3:1]);
  assign end_sum  = {1'b0, line_address} + (orl_pkg::ADDR_W + 1)'(count);
  assign room     = orl_pkg::MEM_LIMIT - {1'b0, line_address};

  always_comb begin
    column_next       = column;
    line_kind_next    = line_kind;
    line_address_next = line_address;
    prev_end_next     = prev_end;
    none_yet_next     = none_yet;
    data_bytes_next   = data_bytes;
    hex_count_next    = hex_count;
    data_ended_next   = data_ended;
    line_ok_next      = line_ok;
    line_count_next   = line_count;
    halted_next       = halted;
    n_writes          = '0;
    do_close          = 1'b0;

    if (halted == orl_pkg::STATUS_OK) begin
      if (char_word.end_of_file) begin
        do_close = (column != 5'd0);
      end else begin
        if (column == 5'd0 && line_count != '1) begin
          line_count_next = line_count + orl_pkg::LINE_W'(1);
        end
        if (char_word.ch == CH_NEWLINE) begin
          do_close = 1'b1;
        end else begin
          // character at the current column
          if (column <= 5'd21) begin
            if (char_word.ch != CH_SPACE) begin
              line_kind_next = KIND_RECORD;
            end else if (column == 5'd21 && line_kind == KIND_UNDECIDED) begin
              line_kind_next = KIND_COMMENT;
            end
          end
          if (column == 5'd2) begin
            if (char_word.ch != CH_ZERO) line_ok_next = 1'b0;
          end else if (column == 5'd3) begin
            if (char_word.ch != CH_X) line_ok_next = 1'b0;
          end else if (column >= 5'd4 && column <= 5'd6) begin
            if (!hex_ok) line_ok_next = 1'b0;
            else line_address_next = {line_address[orl_pkg::ADDR_W-5:0], hex_val};
          end else if (column == 5'd7) begin
            if (char_word.ch != CH_COLON) line_ok_next = 1'b0;
          end else if (column == 5'd8) begin
            if (char_word.ch != CH_SPACE) line_ok_next = 1'b0;
          end else if (column >= 5'd9 && column <= 5'd21) begin
            if (!data_ended) begin
              if (char_word.ch == CH_SPACE) begin
                data_ended_next = 1'b1;
                if (hex_count[0]) line_ok_next = 1'b0;
              end else if (!hex_ok || hex_count >= MAX_HEX) begin
                line_ok_next = 1'b0;
              end else begin
                if (hex_count[0]) begin
                  data_bytes_next[byte_idx] = {data_bytes[byte_idx][3:0], hex_val};
                end else begin
                  data_bytes_next[byte_idx] = {4'd0, hex_val};
                end
                hex_count_next = hex_count + 4'd1;
              end
            end
          end else if (column == 5'd22) begin
            if (char_word.ch != CH_BAR || !data_ended) line_ok_next = 1'b0;
          end
          if (column != 5'd31) column_next = column + 5'd1;
        end
      end

      if (do_close) begin
        if (line_kind != KIND_COMMENT) begin
          if (!line_ok || column < 5'd23 || !data_ended) begin
            halted_next = orl_pkg::STATUS_FORMAT;
          end else if (!none_yet && {1'b0, line_address} < prev_end) begin
            halted_next = orl_pkg::STATUS_FORMAT;
          end else if (count != '0 && end_sum > orl_pkg::MEM_LIMIT) begin
            // bytes below the memory top still go out
            halted_next = orl_pkg::STATUS_MEMORY;
            if ({1'b0, line_address} < orl_pkg::MEM_LIMIT) begin
              n_writes = orl_pkg::COUNT_W'(room);
            end
          end else begin
            n_writes      = count;
            prev_end_next = end_sum;
            none_yet_next = 1'b0;
          end
        end
        column_next       = 5'd0;
        line_kind_next    = KIND_UNDECIDED;
        line_address_next = '0;
        hex_count_next    = 4'd0;
        data_ended_next   = 1'b0;
        line_ok_next      = 1'b1;
      end

      if (char_word.end_of_file && halted_next == orl_pkg::STATUS_OK) begin
        halted_next = orl_pkg::STATUS_DONE;
      end
    end
  end

  always_comb begin
    job.n_writes   = n_writes;
    job.base       = line_address;
    job.bytes      = data_bytes;
    job.status     = halted_next;
    job.line_count = line_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= 5'd0;
      line_kind    <= KIND_UNDECIDED;
      line_address <= '0;
      prev_end     <= '0;
      none_yet     <= 1'b1;
      hex_count    <= 4'd0;
      data_ended   <= 1'b0;
      line_ok      <= 1'b1;
      line_count   <= '0;
      halted       <= orl_pkg::STATUS_OK;
    end else if (push) begin
      column       <= column_next;
      line_kind    <= line_kind_next;
      line_address <= line_address_next;
      prev_end     <= prev_end_next;
      none_yet     <= none_yet_next;
      hex_count    <= hex_count_next;
      data_ended   <= data_ended_next;
      line_ok      <= line_ok_next;
      line_count   <= line_count_next;
      halted       <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_bytes <= data_bytes_next;
    end
  end

endmodule

### hdl/orl_queue.sv
// Two-entry job queue between front and back ends.
module orl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  orl_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output orl_pkg::job_t head
);

  orl_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hdl/orl_back.sv
// Back end: expands one job into its byte writes and the closing status word.
module orl_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  orl_pkg::job_t         head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output orl_pkg::result_word_t result_word
);

  logic [orl_pkg::COUNT_W-1:0] idx;
  logic                        load;
  logic                        at_status;
  orl_pkg::result_word_t       word_next;

  assign load      = !result_valid || !result_stall;
  assign at_status = (idx >= head.n_writes);
  assign pop       = load && !q_empty && at_status;

  always_comb begin
    word_next.error_line = head.line_count;
    if (at_status) begin
      word_next.write_valid   = 1'b0;
      word_next.write_address = '0;
      word_next.write_data    = 8'd0;
      word_next.status        = head.status;
      word_next.last          = 1'b1;
    end else begin
      word_next.write_valid   = 1'b1;
      word_next.write_address = head.base + orl_pkg::ADDR_W'(idx);
      word_next.write_data    = head.bytes[idx];
      word_next.status        = orl_pkg::STATUS_OK;
      word_next.last          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= !q_empty;
      if (!q_empty) begin
        idx <= at_status ? '0 : idx + orl_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      result_word <= word_next;
    end
  end

endmodule

### hdl/object_record_loader.sv
// Object record loader top level: front end, job queue, back end.
//
// Takes one character a cycle while char_stall is low and checks each line of the
// object file against its fixed columns; every accepted character yields one
// status word, and the close of a good data line (newline or end of file) is
// preceded by one write word per data byte (up to six); a line of n bytes ends
// in n+1 output words; the back end emits one word a cycle while result_stall
// is low, and a two-entry job queue lets the front end keep taking characters
// meanwhile, so input stalls only while the queue is full, as right after a data
// line or when the output is held. Status is sticky: after a format error, memory
// error or end of file every character gives only the status word, until reset.
module object_record_loader (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  orl_pkg::char_word_t   char_word,
  output logic                  result_valid,
  input  logic                  result_stall,
  output orl_pkg::result_word_t result_word
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  orl_pkg::job_t front_job;
  orl_pkg::job_t head;

  orl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .q_full     (q_full),
    .push       (push),
    .job        (front_job)
  );

  orl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  orl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("job popped from empty queue");

  a_write_word_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_word.write_valid) |->
      (result_word.status == orl_pkg::STATUS_OK && !result_word.last))
    else $error("write word carries status or last");

endmodule

### bench/record_load_checker.sv
// Checker for the object record loader: predicts every result word and compares.
module record_load_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  input  logic                  char_stall,
  input  orl_pkg::char_word_t   char_word,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  orl_pkg::result_word_t result_word,
  output int                    errors,
  output int                    pending
);
  import orl_pkg::*;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BAR     = 8'h7C;

  localparam int COL_ZERO       = 2;
  localparam int COL_X          = 3;
  localparam int COL_ADDR_FIRST = 4;
  localparam int COL_ADDR_LAST  = 6;
  localparam int COL_COLON      = 7;
  localparam int COL_GAP        = 8;
  localparam int COL_DATA_FIRST = 9;
  localparam int COL_HEAD_LAST  = 21;
  localparam int COL_BAR        = 22;
  localparam int LINE_MIN       = 23;
  localparam int COL_MAX        = 31;

  typedef enum logic [1:0] {LINE_OPEN, LINE_COMMENT, LINE_RECORD} line_kind_t;

  // Loader state as seen by the prediction
  logic [4:0]        column;
  line_kind_t        kind;
  logic [ADDR_W-1:0] line_addr;
  logic [ADDR_W:0]   prev_end;
  logic              none_yet;
  logic [7:0]        data_bytes [MAX_DATA_BYTES];
  logic [3:0]        hex_count;
  logic              data_ended;
  logic              line_ok;
  logic [LINE_W-1:0] line_count;
  status_t           halted;

  result_word_t expected_words[$];
  int fail_total = 0;

  assign errors = fail_total;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_total < 50)
      $display("[%0t] result mismatch on %s: got %h, want %h", $time, what, got, want);
    fail_total++;
  endtask

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic expect_word(input logic wv, input logic [ADDR_W-1:0] addr,
                             input logic [7:0] data, input status_t st, input logic last);
    result_word_t r;
    r.write_valid   = wv;
    r.write_address = addr;
    r.write_data    = data;
    r.status        = st;
    r.error_line    = line_count;
    r.last          = last;
    expected_words.push_back(r);
  endtask

  task automatic clear_line();
    column     = '0;
    kind       = LINE_OPEN;
    line_addr  = '0;
    hex_count  = '0;
    data_ended = 1'b0;
    line_ok    = 1'b1;
  endtask

  task automatic take_char(input logic [7:0] c);
    int h;
    int idx;
    h = nibble_of(c);
    if (column <= COL_HEAD_LAST) begin
      if (c != CH_SPACE) kind = LINE_RECORD;
      else if (column == COL_HEAD_LAST && kind == LINE_OPEN) kind = LINE_COMMENT;
    end
    if (column == COL_ZERO) begin
      if (c != CH_ZERO) line_ok = 1'b0;
    end else if (column == COL_X) begin
      if (c != CH_X) line_ok = 1'b0;
    end else if (column >= COL_ADDR_FIRST && column <= COL_ADDR_LAST) begin
      if (h < 0) line_ok = 1'b0;
      else line_addr = {line_addr[ADDR_W-5:0], 4'(h)};
    end else if (column == COL_COLON) begin
      if (c != CH_COLON) line_ok = 1'b0;
    end else if (column == COL_GAP) begin
      if (c != CH_SPACE) line_ok = 1'b0;
    end else if (column >= COL_DATA_FIRST && column <= COL_HEAD_LAST) begin
      if (!data_ended) begin
        if (c == CH_SPACE) begin
          data_ended = 1'b1;
          if (hex_count[0]) line_ok = 1'b0;
        end else if (h < 0 || hex_count >= 2 * MAX_DATA_BYTES) begin
          line_ok = 1'b0;
        end else begin
          idx = hex_count >> 1;
          if (hex_count[0]) data_bytes[idx] = {data_bytes[idx][3:0], 4'(h)};
          else data_bytes[idx] = {4'h0, 4'(h)};
          hex_count++;
        end
      end
    end else if (column == COL_BAR) begin
      if (c != CH_BAR || !data_ended) line_ok = 1'b0;
    end
    if (column < COL_MAX) column++;
  endtask

  // Closes the line: a good record turns into one write per data byte, up to the memory top.
  task automatic finish_line();
    int count;
    int i;
    logic [ADDR_W:0] a;
    if (kind != LINE_COMMENT) begin
      if (!line_ok || column < LINE_MIN || !data_ended) begin
        halted = STATUS_FORMAT;
      end else if (!none_yet && {1'b0, line_addr} < prev_end) begin
        halted = STATUS_FORMAT;
      end else begin
        count = hex_count >> 1;
        for (i = 0; i < count && halted == STATUS_OK; i++) begin
          a = {1'b0, line_addr} + (ADDR_W + 1)'(i);
          if (a >= MEM_LIMIT || a[ADDR_W]) halted = STATUS_MEMORY;
          else expect_word(1'b1, a[ADDR_W-1:0], data_bytes[i], STATUS_OK, 1'b0);
        end
        if (halted == STATUS_OK) begin
          prev_end = {1'b0, line_addr} + (ADDR_W + 1)'(count);
          none_yet = 1'b0;
        end
      end
    end
    clear_line();
  endtask

  task automatic predict_word(input char_word_t w);
    if (halted == STATUS_OK) begin
      if (w.end_of_file) begin
        if (column > 0) finish_line();
        if (halted == STATUS_OK) halted = STATUS_DONE;
      end else begin
        if (column == 0 && line_count != '1) line_count++;
        if (w.ch == CH_NEWLINE) finish_line();
        else take_char(w.ch);
      end
    end
    // every accepted word ends with one status word
    expect_word(1'b0, '0, '0, halted, 1'b1);
  endtask

  always @(posedge clk) begin : watch
    result_word_t want;
    if (rst) begin
      clear_line();
      prev_end   = '0;
      none_yet   = 1'b1;
      line_count = '0;
      halted     = STATUS_OK;
      expected_words.delete();
    end else begin
      if (char_valid && !char_stall) predict_word(char_word);
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          report("word with nothing expected, address", result_word.write_address, '0);
        end else begin
          want = expected_words.pop_front();
          if (result_word.write_valid !== want.write_valid)
            report("write_valid", result_word.write_valid, want.write_valid);
          if (result_word.write_address !== want.write_address)
            report("write_address", result_word.write_address, want.write_address);
          if (result_word.write_data !== want.write_data)
            report("write_data", result_word.write_data, want.write_data);
          if (result_word.status !== want.status)
            report("status", result_word.status, want.status);
          if (result_word.error_line !== want.error_line)
            report("error_line", result_word.error_line, want.error_line);
          if (result_word.last !== want.last)
            report("last", result_word.last, want.last);
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

### bench/tb_top.sv
// Testbench top for the object record loader: character stimulus, result stalls, verdict.
module tb_top;
  import orl_pkg::*;

  localparam int BAR_COL = 22;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         char_valid = 1'b0;
  logic         char_stall;
  char_word_t   char_word = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result_word;
  int           errors;
  int           pending;

  logic [7:0]      line_chars[$];
  int              items_sent = 0;
  int              burst_left = 0;
  logic [ADDR_W:0] next_free = '0;  // lowest address a new record may use
  bit              any_loaded = 1'b0;

  object_record_loader dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  record_load_checker load_check (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // any byte except newline
  function automatic logic [7:0] any_char();
    logic [7:0] c;
    c = $urandom_range(0, 255);
    if (c == "\n") c = 8'h0B;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return "0" + v;
    return ($urandom_range(0, 1) ? "a" : "A") - 8'd10 + v;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W:0] a;
    if (!any_loaded) a = ($urandom_range(0, 2) == 0) ? '0 : (ADDR_W + 1)'($urandom_range(0, 255));
    else if ($urandom_range(0, 3) == 0) a = next_free;
    else a = next_free + (ADDR_W + 1)'($urandom_range(1, 200));
    if (a > 13'hE00) a = next_free;
    return a[ADDR_W-1:0];
  endfunction

  task automatic note_loaded(input logic [ADDR_W-1:0] addr, input int nbytes);
    next_free  = {1'b0, addr} + (ADDR_W + 1)'(nbytes);
    any_loaded = 1'b1;
  endtask

  // Well-formed record: address, nbytes of data, filler up to the bar, then a tail.
  task automatic build_record(input logic [ADDR_W-1:0] addr, input int nbytes, input int tail_len);
    logic [7:0] b;
    line_chars.delete();
    repeat (2) line_chars.push_back(($urandom_range(0, 3) == 0) ? any_char() : " ");
    line_chars.push_back("0");
    line_chars.push_back("x");
    for (int i = 2; i >= 0; i--) line_chars.push_back(hex_char(addr[4*i +: 4]));
    line_chars.push_back(":");
    line_chars.push_back(" ");
    repeat (nbytes) begin
      b = $urandom;
      line_chars.push_back(hex_char(b[7:4]));
      line_chars.push_back(hex_char(b[3:0]));
    end
    line_chars.push_back(" ");
    while (line_chars.size() < BAR_COL) line_chars.push_back(any_char());
    line_chars.push_back("|");
    repeat (tail_len) line_chars.push_back(any_char());
  endtask

  task automatic send_word(input logic [7:0] c, input logic eof);
    char_word_t w;
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 3);
        default: gap = $urandom_range(4, 12);
      endcase
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    w.ch = c;
    w.end_of_file = eof;
    char_valid <= 1'b1;
    char_word  <= w;
    do @(posedge clk); while (char_stall);
    items_sent++;
  endtask

  task automatic send_line(input bit with_newline);
    foreach (line_chars[i]) send_word(line_chars[i], 1'b0);
    if (with_newline) send_word("\n", 1'b0);
    line_chars.delete();
  endtask

  // result side: stall patterns in stretches, plus one long hold to back up the block
  initial begin : drain_side
    int cyc;
    int mode_left;
    int stall_pct;
    int hold_left;
    cyc = 0;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 100) hold_left = 100;
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(8, 60);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : feed_side
    string first_line;
    int line_no;
    int nbytes;
    int tail;
    int pick;
    int cut;
    logic [ADDR_W-1:0] addr;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // six bytes at address zero, both case forms, extreme bytes in the tail
    first_line = "  0x000: 00ff0A1b2C3d |";
    for (int i = 0; i < first_line.len(); i++) line_chars.push_back(first_line[i]);
    line_chars.push_back(8'h00);
    line_chars.push_back(8'hFF);
    send_line(1'b1);
    note_loaded('0, 6);

    line_no = 0;
    while (items_sent < 300) begin
      if (line_no == 6) begin
        char_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      tail = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 3);
      if (line_no == 0 || (line_no > 2 && $urandom_range(0, 4) == 0)) begin
        // comment: 22 spaces then anything
        repeat (BAR_COL) line_chars.push_back(" ");
        repeat (tail) line_chars.push_back(any_char());
        send_line(1'b1);
      end else begin
        if (line_no == 1) nbytes = 0;
        else if (line_no == 2) nbytes = MAX_DATA_BYTES;
        else nbytes = $urandom_range(0, MAX_DATA_BYTES);
        addr = pick_address();
        build_record(addr, nbytes, tail);
        send_line(1'b1);
        note_loaded(addr, nbytes);
      end
      line_no++;
    end

    // one way of stopping the load; status is sticky from here on
    case ($urandom_range(0, 5))
      0: ;
      1: begin  // record left open, end of file closes it
        nbytes = $urandom_range(0, MAX_DATA_BYTES);
        addr = pick_address();
        build_record(addr, nbytes, $urandom_range(0, 5));
        send_line(1'b0);
        note_loaded(addr, nbytes);
      end
      2: begin  // address below the end of the previous record
        addr = $urandom_range(0, next_free - 1);
        build_record(addr, $urandom_range(0, MAX_DATA_BYTES), $urandom_range(0, 3));
        send_line(1'b1);
      end
      3: begin  // runs off the top of memory
        addr = 12'hFFF - $urandom_range(0, 4);
        build_record(addr, MAX_DATA_BYTES, 0);
        send_line(1'b1);
      end
      4: begin  // one checked column broken
        nbytes = $urandom_range(0, MAX_DATA_BYTES);
        build_record(pick_address(), nbytes, $urandom_range(0, 3));
        pick = $urandom_range(2, 10 + 2 * nbytes);
        line_chars[(pick == 10 + 2 * nbytes) ? BAR_COL : pick] = "g";
        send_line(1'b1);
      end
      default: begin  // short or empty line
        build_record(pick_address(), $urandom_range(0, MAX_DATA_BYTES), 0);
        cut = $urandom_range(0, BAR_COL);
        while (line_chars.size() > cut) void'(line_chars.pop_back());
        send_line(1'b1);
      end
    endcase

    repeat ($urandom_range(3, 10)) send_word($urandom_range(0, 255), $urandom_range(0, 3) == 0);
    send_word($urandom_range(0, 255), 1'b1);

    char_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
